/* sv/heap_sort_engine_unit_assert.svh */
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Shared concurrent assertion forms used by the engine modules.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_UNIT_ASSERT_SVH
`define HEAP_SORT_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define HSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heap sort engine check failed");

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define HSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heap sort engine check failed");

`endif

/* sv/hse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sort engine package
// Shared constants, state encodings and interface structs.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned MaxItemsDefault = 64;
  localparam int unsigned DataW = 32;

  typedef enum logic [3:0] {
    TOP_LOAD,
    TOP_BRD,
    TOP_BKEY,
    TOP_BSIFT,
    TOP_XRD0,
    TOP_XRDK,
    TOP_XSWAP,
    TOP_XSIFT,
    TOP_ERD,
    TOP_EOUT
  } top_state_e;

  typedef enum logic [2:0] {
    SIFT_IDLE,
    SIFT_LEFT,
    SIFT_RIGHT,
    SIFT_PICK,
    SIFT_MOVE
  } sift_state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sift_stat_t;

endpackage

/* sv/heap_sort_engine_unit.sv */
`timescale 1ns / 1ps
`include "heap_sort_engine_unit_assert.svh"
// ----------------------------------------------------------------------------
// Heap sort engine
// Collects a set of signed values, heap sorts them in place and returns
// them in ascending order.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_stall_o) carries one value per
// transaction; a transaction with last_i set closes the set. Up to MAX_ITEMS
// values are kept; further ones are dropped and every result of that set
// then carries overflow_o. The output channel (out_valid_o, out_stall_i)
// returns each kept value in ascending order, the final one with last_res_o.
// Loading accepts one value per cycle. After the closing transaction the block
// stalls its input while it builds the heap and extracts the maximum N-1
// times. Each sift-down goes through the shared comparator one heap level
// at a time, in SIFT_LEFT, SIFT_RIGHT, SIFT_PICK and SIFT_MOVE. Results leave
// through a single output register, each read in TOP_ERD and loaded in TOP_EOUT. A
// stall on the output holds that register and pauses the readout; once the
// final result is in the register the input opens for the next set.
// Reset clears the element count, the drop flag behind overflow_o and the
// output valid.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = hse_pkg::MaxItemsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [hse_pkg::DataW-1:0] value_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [hse_pkg::DataW-1:0] sorted_value_o,
  output logic                            last_res_o,
  output logic                            overflow_o
);

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned DataW = hse_pkg::DataW;

  hse_pkg::top_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [DataW-1:0] max_q, max_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] sorted_q;
  logic             last_res_q;
  logic             overflow_q;

  logic             in_fire;
  logic [CntW-1:0]  cnt_inc;
  logic             emit_last;
  logic             out_load;
  logic             sift_active;

  hse_pkg::mem_cmd_t top_cmd, mem_cmd, sift_cmd;
  logic [AddrW-1:0]  top_raddr, top_waddr, mem_raddr, mem_waddr;
  logic [AddrW-1:0]  sift_raddr, sift_waddr;
  logic [DataW-1:0]  top_wdata, mem_wdata, sift_wdata, rdata;

  logic              sift_start;
  logic [AddrW-1:0]  sift_hole;
  logic [CntW-1:0]   sift_size;
  logic [DataW-1:0]  sift_key;
  hse_pkg::sift_stat_t sift_stat;

  assign in_stall_o = (state_q != hse_pkg::TOP_LOAD);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cnt_inc    = cnt_q + CntW'(1);
  assign emit_last  = ({1'b0, idx_q} + CntW'(1)) == cnt_q;
  assign sift_active = (state_q == hse_pkg::TOP_BSIFT) || (state_q == hse_pkg::TOP_XSIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hse_pkg::TOP_LOAD;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    max_q <= max_d;
    if (out_load) begin
      sorted_q   <= rdata;
      last_res_q <= emit_last;
      overflow_q <= drop_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    drop_d     = drop_q;
    idx_d      = idx_q;
    max_d      = max_q;
    top_cmd    = '0;
    top_raddr  = idx_q;
    top_waddr  = idx_q;
    top_wdata  = max_q;
    sift_start = 1'b0;
    sift_hole  = idx_q;
    sift_size  = cnt_q;
    sift_key   = rdata;
    out_load   = 1'b0;
    case (state_q)
      hse_pkg::TOP_LOAD: begin
        if (in_fire) begin
          if (cnt_q < CntW'(MAX_ITEMS)) begin
            top_cmd.wr_en = 1'b1;
            top_waddr     = cnt_q[AddrW-1:0];
            top_wdata     = value_i;
            cnt_d         = cnt_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            if (cnt_d < CntW'(2)) begin
              idx_d   = '0;
              state_d = hse_pkg::TOP_ERD;
            end else begin
              idx_d   = AddrW'((cnt_d - CntW'(1)) >> 1);
              state_d = hse_pkg::TOP_BRD;
            end
          end
        end
      end
      hse_pkg::TOP_BRD: begin
        top_cmd.rd_en = 1'b1;
        state_d       = hse_pkg::TOP_BKEY;
      end
      hse_pkg::TOP_BKEY: begin
        sift_start = 1'b1;
        state_d    = hse_pkg::TOP_BSIFT;
      end
      hse_pkg::TOP_BSIFT: begin
        if (sift_stat.done) begin
          if (idx_q == '0) begin
            idx_d   = AddrW'(cnt_q - CntW'(1));
            state_d = hse_pkg::TOP_XRD0;
          end else begin
            idx_d   = idx_q - AddrW'(1);
            state_d = hse_pkg::TOP_BRD;
          end
        end
      end
      hse_pkg::TOP_XRD0: begin
        top_cmd.rd_en = 1'b1;
        top_raddr     = '0;
        state_d       = hse_pkg::TOP_XRDK;
      end
      hse_pkg::TOP_XRDK: begin
        max_d         = rdata;
        top_cmd.rd_en = 1'b1;
        state_d       = hse_pkg::TOP_XSWAP;
      end
      hse_pkg::TOP_XSWAP: begin
        top_cmd.wr_en = 1'b1;
        sift_start    = 1'b1;
        sift_hole     = '0;
        sift_size     = {1'b0, idx_q};
        state_d       = hse_pkg::TOP_XSIFT;
      end
      hse_pkg::TOP_XSIFT: begin
        if (sift_stat.done) begin
          if (idx_q == AddrW'(1)) begin
            idx_d   = '0;
            state_d = hse_pkg::TOP_ERD;
          end else begin
            idx_d   = idx_q - AddrW'(1);
            state_d = hse_pkg::TOP_XRD0;
          end
        end
      end
      hse_pkg::TOP_ERD: begin
        top_cmd.rd_en = 1'b1;
        state_d       = hse_pkg::TOP_EOUT;
      end
      hse_pkg::TOP_EOUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (emit_last) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = hse_pkg::TOP_LOAD;
          end else begin
            idx_d   = idx_q + AddrW'(1);
            state_d = hse_pkg::TOP_ERD;
          end
        end
      end
      default: begin
        state_d = hse_pkg::TOP_LOAD;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign mem_cmd   = sift_active ? sift_cmd : top_cmd;
  assign mem_raddr = sift_active ? sift_raddr : top_raddr;
  assign mem_waddr = sift_active ? sift_waddr : top_waddr;
  assign mem_wdata = sift_active ? sift_wdata : top_wdata;

  hse_store #(
    .Depth (MAX_ITEMS),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .raddr_i (mem_raddr),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  hse_sift #(
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_sift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sift_start),
    .hole_i  (sift_hole),
    .size_i  (sift_size),
    .key_i   (sift_key),
    .rdata_i (rdata),
    .cmd_o   (sift_cmd),
    .raddr_o (sift_raddr),
    .waddr_o (sift_waddr),
    .wdata_o (sift_wdata),
    .stat_o  (sift_stat)
  );

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = $signed(sorted_q);
  assign last_res_o     = last_res_q;
  assign overflow_o     = overflow_q;

  `HSE_ASSERT_NOW(a_sift_busy_in_wait, sift_stat.busy, sift_active)
  `HSE_ASSERT_NOW(a_count_in_range, 1'b1, cnt_q <= CntW'(MAX_ITEMS))
  `HSE_ASSERT_NEXT(a_final_result_reloads, out_load && emit_last,
                   state_q == hse_pkg::TOP_LOAD && cnt_q == '0 && out_valid_q)

endmodule

/* sv/hse_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sort engine element store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module hse_store #(
  parameter int unsigned Depth = hse_pkg::MaxItemsDefault,
  parameter int unsigned AddrW = $clog2(hse_pkg::MaxItemsDefault),
  parameter int unsigned DataW = hse_pkg::DataW
) (
  input  logic             clk_i,
  input  hse_pkg::mem_cmd_t cmd_i,
  input  logic [AddrW-1:0] raddr_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/hse_sift.sv */
`timescale 1ns / 1ps
`include "heap_sort_engine_unit_assert.svh"
// ----------------------------------------------------------------------------
// Heap sort engine sift-down unit
// Moves a key down from a hole in the heap, one level per pass through
// SIFT_LEFT, SIFT_RIGHT, SIFT_PICK and SIFT_MOVE, using a single shared signed comparator.
// ----------------------------------------------------------------------------
module hse_sift #(
  parameter int unsigned AddrW = $clog2(hse_pkg::MaxItemsDefault),
  parameter int unsigned DataW = hse_pkg::DataW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AddrW-1:0]   hole_i,
  input  logic [AddrW:0]     size_i,
  input  logic [DataW-1:0]   key_i,
  input  logic [DataW-1:0]   rdata_i,
  output hse_pkg::mem_cmd_t  cmd_o,
  output logic [AddrW-1:0]   raddr_o,
  output logic [AddrW-1:0]   waddr_o,
  output logic [DataW-1:0]   wdata_o,
  output hse_pkg::sift_stat_t stat_o
);

  hse_pkg::sift_state_e state_q, state_d;
  logic [AddrW-1:0] hole_q, hole_d;
  logic [AddrW:0]   size_q, size_d;
  logic [DataW-1:0] key_q, key_d;
  logic [DataW-1:0] cand_q, cand_d;
  logic [AddrW-1:0] cidx_q, cidx_d;
  logic             rc_ok_q, rc_ok_d;

  logic [AddrW+1:0] lc_w;
  logic [AddrW+1:0] rc_w;
  logic [AddrW+1:0] size_w;
  logic [DataW-1:0] cmp_a;
  logic [DataW-1:0] cmp_b;
  logic             cmp_gt;
  logic             move_down;

  assign lc_w   = {1'b0, hole_q, 1'b1};
  assign rc_w   = lc_w + (AddrW+2)'(1);
  assign size_w = {1'b0, size_q};

  assign cmp_a  = (state_q == hse_pkg::SIFT_PICK) ? rdata_i : cand_q;
  assign cmp_b  = (state_q == hse_pkg::SIFT_PICK) ? cand_q : key_q;
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  assign move_down = (state_q == hse_pkg::SIFT_MOVE) && cmp_gt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hse_pkg::SIFT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q  <= hole_d;
    size_q  <= size_d;
    key_q   <= key_d;
    cand_q  <= cand_d;
    cidx_q  <= cidx_d;
    rc_ok_q <= rc_ok_d;
  end

  always_comb begin
    state_d     = state_q;
    hole_d      = hole_q;
    size_d      = size_q;
    key_d       = key_q;
    cand_d      = cand_q;
    cidx_d      = cidx_q;
    rc_ok_d     = rc_ok_q;
    cmd_o       = '0;
    raddr_o     = '0;
    waddr_o     = hole_q;
    wdata_o     = key_q;
    stat_o.busy = (state_q != hse_pkg::SIFT_IDLE);
    stat_o.done = 1'b0;
    case (state_q)
      hse_pkg::SIFT_IDLE: begin
        if (start_i) begin
          hole_d  = hole_i;
          size_d  = size_i;
          key_d   = key_i;
          state_d = hse_pkg::SIFT_LEFT;
        end
      end
      hse_pkg::SIFT_LEFT: begin
        if (lc_w >= size_w) begin
          cmd_o.wr_en = 1'b1;
          stat_o.done = 1'b1;
          state_d     = hse_pkg::SIFT_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = lc_w[AddrW-1:0];
          state_d     = hse_pkg::SIFT_RIGHT;
        end
      end
      hse_pkg::SIFT_RIGHT: begin
        cand_d  = rdata_i;
        cidx_d  = lc_w[AddrW-1:0];
        rc_ok_d = (rc_w < size_w);
        if (rc_w < size_w) begin
          cmd_o.rd_en = 1'b1;
          raddr_o     = rc_w[AddrW-1:0];
        end
        state_d = hse_pkg::SIFT_PICK;
      end
      hse_pkg::SIFT_PICK: begin
        if (rc_ok_q && cmp_gt) begin
          cand_d = rdata_i;
          cidx_d = rc_w[AddrW-1:0];
        end
        state_d = hse_pkg::SIFT_MOVE;
      end
      hse_pkg::SIFT_MOVE: begin
        cmd_o.wr_en = 1'b1;
        if (cmp_gt) begin
          wdata_o = cand_q;
          hole_d  = cidx_q;
          state_d = hse_pkg::SIFT_LEFT;
        end else begin
          stat_o.done = 1'b1;
          state_d     = hse_pkg::SIFT_IDLE;
        end
      end
      default: begin
        state_d = hse_pkg::SIFT_IDLE;
      end
    endcase
  end

  `HSE_ASSERT_NOW(a_start_when_idle, start_i, state_q == hse_pkg::SIFT_IDLE)
  `HSE_ASSERT_NOW(a_done_writes, stat_o.done, cmd_o.wr_en)
  `HSE_ASSERT_NEXT(a_hole_descends, move_down, hole_q > $past(hole_q))

endmodule

/* sim/tb_heap_sort_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap sort engine testbench
// Sends sets of signed values, closed by last_i, into the engine and checks
// each returned value, its last flag and its overflow flag against a sorted
// copy of the set that the bench keeps itself. Covers single values, the
// extremes, equal keys, full and overflowing sets, and random sets with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_heap_sort_engine_unit;

  localparam int unsigned MaxItems = hse_pkg::MaxItemsDefault;
  localparam int unsigned DataW = hse_pkg::DataW;
  localparam int DrainCycles = 200;
  localparam time RunLimit = 6ms;

  localparam logic signed [DataW-1:0] ValMin = {1'b1, {(DataW-1){1'b0}}};
  localparam logic signed [DataW-1:0] ValMax = {1'b0, {(DataW-1){1'b1}}};

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
    logic                    overflow;
  } sorted_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [DataW-1:0] value_i;
  logic                    last_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] sorted_value_o;
  logic                    last_res_o;
  logic                    overflow_o;

  logic signed [DataW-1:0] held_values[$];
  logic                    held_dropped;
  sorted_result_t          pending_results[$];
  int                      error_count;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      recv_stall_left;

  heap_sort_engine_unit #(
    .MAX_ITEMS(MaxItems)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .overflow_o    (overflow_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimit);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("Mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Keeps the held set in ascending order and releases it when the set closes.
  task automatic sort_accept(input logic signed [DataW-1:0] v, input logic l);
    int pos;
    int n;
    sorted_result_t res;
    if (held_values.size() < MaxItems) begin
      pos = 0;
      while (pos < held_values.size() && held_values[pos] <= v) pos++;
      held_values.insert(pos, v);
    end else begin
      held_dropped = 1'b1;
    end
    if (l) begin
      n = held_values.size();
      for (int k = 0; k < n; k++) begin
        res.value    = held_values[k];
        res.last     = (k == n - 1);
        res.overflow = held_dropped;
        pending_results.push_back(res);
      end
      held_values.delete();
      held_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic signed [DataW-1:0] v, input logic l);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    value_i    = v;
    last_i     = l;
    do @(posedge clk_i); while (in_stall_o);
    sort_accept(v, l);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic pick_idling();
    int choice [3] = '{0, 15, 40};
    send_idle_pct = choice[$urandom_range(0, 2)];
    recv_idle_pct = choice[$urandom_range(0, 2)];
  endtask

  function automatic logic signed [DataW-1:0] random_value();
    logic signed [DataW-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = ValMin;
          1: v = ValMax;
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_set(input int count);
    for (int k = 0; k < count; k++) send_item(random_value(), k == count - 1);
  endtask

  task automatic test_single_values();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_item(ValMin, 1'b1);
    send_item(ValMax, 1'b1);
    send_item('0, 1'b1);
    send_item('1, 1'b1);
    wait_drained();
  endtask

  task automatic test_extremes_and_ties();
    send_item(ValMax, 1'b0);
    send_item(ValMin, 1'b0);
    send_item(32'sd0, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(ValMax, 1'b0);
    send_item(ValMin, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b1);
    send_item(32'sd7, 1'b0);
    send_item(-32'sd7, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int count;
    for (int s = 0; s < 24; s++) begin
      pick_idling();
      count = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 10) : $urandom_range(11, 40);
      send_random_set(count);
      if (s % 8 == 7) wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_capacity();
    pick_idling();
    send_random_set(MaxItems);
    wait_drained();
    pick_idling();
    send_random_set(MaxItems + 6);
    pick_idling();
    send_random_set(MaxItems + 1);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int s = 0; s < 3; s++) send_random_set($urandom_range(4, 8));
    wait_drained();
  endtask

  initial begin
    recv_stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_stall_left > 0) begin
        recv_stall_left--;
        out_stall_i = 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        recv_stall_left = $urandom_range(1, 6) - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sorted_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", sorted_value_o));
      end else begin
        want = pending_results.pop_front();
        if (sorted_value_o !== want.value)
          report_mismatch($sformatf("sorted_value got %0d, expected %0d",
                                    sorted_value_o, want.value));
        if (last_res_o !== want.last)
          report_mismatch($sformatf("last_res got %b, expected %b", last_res_o, want.last));
        if (overflow_o !== want.overflow)
          report_mismatch($sformatf("overflow got %b, expected %b",
                                    overflow_o, want.overflow));
      end
    end
  end

  initial begin
    error_count   = 0;
    held_dropped  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    last_i        = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_values();
    test_extremes_and_ties();
    test_random_sets();
    test_capacity();
    test_back_to_back();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/hse_pkg.sv
sv/hse_store.sv
sv/hse_sift.sv
sv/heap_sort_engine_unit.sv
sim/tb_heap_sort_engine_unit.sv
